// File: hdl/ccx_pkg.sv
// Package with the command codes, the result record and the helper functions of the cheat code decoder.
package ccx_pkg;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_WRITE = 3'd1,
    OP_FILL  = 3'd2,
    OP_COPY  = 3'd3,
    OP_DELAY = 3'd4,
    OP_END   = 3'd5
  } op_kind_t;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_BAD  = 2'd3;

  localparam logic [31:0] RAM_LOW      = 32'h8000_0000;
  localparam logic [31:0] RAM_HIGH     = 32'h8180_0000;
  localparam logic [31:0] ADDR_MASK    = 32'h01FF_FFFF;
  localparam logic [31:0] HW_BASE      = 32'hCC00_0000;
  localparam logic [31:0] HW_WORD_FLAG = 32'h0100_0000;
  localparam logic [31:0] DELAY_FLAG   = 32'h0200_0000;
  localparam logic [31:0] BRANCH_MASK  = 32'h03FF_FFFC;
  localparam logic [31:0] BRANCH_OP    = 32'h4800_0000;
  localparam logic [31:0] HOOK_RESET   = 32'h817F_D000;

  // Special-line selectors.
  localparam logic [2:0] SEL_END   = 3'd0;
  localparam logic [2:0] SEL_DELAY = 3'd1;
  localparam logic [2:0] SEL_FILL  = 3'd4;
  localparam logic [2:0] SEL_COPY  = 3'd7;

  // Condition types.
  localparam logic [2:0] CT_EQ  = 3'd1;
  localparam logic [2:0] CT_NE  = 3'd2;
  localparam logic [2:0] CT_SLT = 3'd3;
  localparam logic [2:0] CT_SGT = 3'd4;
  localparam logic [2:0] CT_ULT = 3'd5;
  localparam logic [2:0] CT_UGT = 3'd6;

  localparam int DATA_W = 160;
  localparam int RES_W  = 152;

  typedef struct packed {
    op_kind_t          op_kind;
    logic [31:0]       mem_address;
    logic [31:0]       mem_data;
    logic [31:0]       copy_source;
    logic [1:0]        access_size;
    logic [23:0]       repeat_count;
    logic signed [15:0] address_step;
    logic [4:0]        advance_bytes;
    logic              skip_to_marker;
  } cmd_t;

  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    unique case (sz)
      SZ_BYTE: size_mask = 32'h0000_00FF;
      SZ_HALF: size_mask = 32'h0000_FFFF;
      default: size_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

  // Sign extension to 33 bits for the comparisons.
  function automatic logic signed [32:0] sext33(input logic [31:0] v, input logic [1:0] sz);
    unique case (sz)
      SZ_BYTE: sext33 = {{25{v[7]}}, v[7:0]};
      SZ_HALF: sext33 = {{17{v[15]}}, v[15:0]};
      default: sext33 = {v[31], v};
    endcase
  endfunction

endpackage

// File: hdl/cheat_code_execute_decoder.sv
// Top level of the cheat code decoder: stream ports, hook register and output register stage.
//
// Channel | Direction | tdata fields, lowest bits first
// in_     | slave     | code_word_first, code_word_second, extra_word_first,
//         |           | extra_word_second, target_value (160 bits)
// out_    | master    | op_kind, mem_address, mem_data, copy_source, access_size,
//         |           | repeat_count, address_step, advance_bytes, skip_to_marker (152 bits)
// cfg_    | write     | hook_target
//
// One word per cycle while the output stage is not stalled; each word passes two
// registered decode stages and one output register stage before its result is presented.
// The pipeline advances whenever its output stage is empty or being taken.
// A stalled word holds in place; in_tready falls only while the output stage is full.
// Synchronous reset empties the pipeline and loads the default hook address.
module cheat_code_execute_decoder
  import ccx_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [DATA_W-1:0] in_tdata, // code_word_first, code_word_second,
                                      // extra_word_first, extra_word_second, target_value
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [RES_W-1:0] out_tdata, // op_kind, mem_address, mem_data, copy_source,
                                      // access_size, repeat_count, address_step,
                                      // advance_bytes, skip_to_marker
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata
);

  logic [31:0] hook_target_r;
  logic        adv_en;
  logic        dec_valid;
  cmd_t        dec_cmd;
  logic        out_tvalid_r;
  logic [RES_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hook_target_r <= HOOK_RESET;
    end else if (cfg_we) begin
      hook_target_r <= cfg_wdata;
    end
  end

  assign adv_en     = !out_tvalid_r || out_tready;
  assign in_tready  = adv_en;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  ccx_decode u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv_en      (adv_en),
    .in_valid    (in_tvalid),
    .hook_target (hook_target_r),
    .w0          (in_tdata[31:0]),
    .w1          (in_tdata[63:32]),
    .e0          (in_tdata[95:64]),
    .e1          (in_tdata[127:96]),
    .tv          (in_tdata[159:128]),
    .out_valid   (dec_valid),
    .out_cmd     (dec_cmd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv_en) begin
      out_tvalid_r <= dec_valid;
    end
    if (adv_en) begin
      out_tdata_r <= {5'd0, dec_cmd.skip_to_marker, dec_cmd.advance_bytes,
                      dec_cmd.address_step, dec_cmd.repeat_count, dec_cmd.access_size,
                      dec_cmd.copy_source, dec_cmd.mem_data, dec_cmd.mem_address,
                      dec_cmd.op_kind};
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == OP_END |-> out_tdata[145:141] == 5'd0)
    else $error("end of list must not advance");

endmodule

// File: hdl/ccx_decode.sv
// Two-stage decode pipeline: field split and compares, then command selection.
module ccx_decode
  import ccx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv_en,
  input  logic        in_valid,
  input  logic [31:0] hook_target,
  input  logic [31:0] w0,
  input  logic [31:0] w1,
  input  logic [31:0] e0,
  input  logic [31:0] e1,
  input  logic [31:0] tv,
  output logic        out_valid,
  output cmd_t        out_cmd
);

  // Stage 1 registers: raw words plus precomputed flags and sums.
  logic        v1_r;
  logic [31:0] w0_r, w1_r, e0_r, e1_r;
  logic        fail_r, ptr_ok_r;
  logic [31:0] ptr_addr_r, add_sum_r, hook_diff_r;

  logic [31:0] m, tu, vu;
  logic signed [32:0] ts, vs;
  logic        fail_nxt;
  logic [31:0] base;
  logic [31:0] ptr_off;

  always_comb begin
    m  = size_mask(w0[26:25]);
    tu = tv & m;
    vu = w1 & m;
    ts = sext33(tv, w0[26:25]);
    vs = (w0[26:25] == SZ_WORD) ? sext33(w1, SZ_WORD) : {1'b0, vu};
    unique case (w0[29:27])
      CT_EQ:   fail_nxt = (tu != vu);
      CT_NE:   fail_nxt = (tu == vu);
      CT_SLT:  fail_nxt = (ts >= vs);
      CT_SGT:  fail_nxt = (ts <= vs);
      CT_ULT:  fail_nxt = (tu >= vu);
      CT_UGT:  fail_nxt = (tu <= vu);
      default: fail_nxt = ((tu & vu) == 32'd0);
    endcase
    base = (w0 & ADDR_MASK) | RAM_LOW;
    unique case (w0[26:25])
      SZ_BYTE: ptr_off = {8'd0, w1[31:8]};
      SZ_HALF: ptr_off = {16'd0, w1[31:16]};
      default: ptr_off = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv_en) begin
      v1_r <= in_valid;
    end
    if (adv_en) begin
      w0_r        <= w0;
      w1_r        <= w1;
      e0_r        <= e0;
      e1_r        <= e1;
      fail_r      <= fail_nxt;
      ptr_ok_r    <= (tv >= RAM_LOW) && (tv <= RAM_HIGH);
      ptr_addr_r  <= tv + ptr_off;
      add_sum_r   <= tv + w1;
      hook_diff_r <= hook_target - base;
    end
  end

  // Stage 2: select the command.
  cmd_t        c;
  logic [1:0]  sz;
  logic [1:0]  sub;
  logic [2:0]  ctype;
  logic [2:0]  sel;
  logic [31:0] bse, hwa;

  always_comb begin
    c     = '0;
    sz    = w0_r[26:25];
    sub   = w0_r[31:30];
    ctype = w0_r[29:27];
    sel   = w1_r[31:29];
    bse   = (w0_r & ADDR_MASK) | RAM_LOW;
    hwa   = bse | HW_BASE;
    c.advance_bytes = 5'd8;
    if (w0_r == 32'd0) begin
      unique case (sel)
        SEL_END: begin
          c.op_kind = OP_END;
          c.advance_bytes = 5'd0;
        end
        SEL_DELAY: begin
          if ((w1_r & DELAY_FLAG) != 32'd0) begin
            c.op_kind = OP_DELAY;
            c.repeat_count = {w1_r[7:0], 16'd0};
          end else begin
            c.advance_bytes = 5'd16;
          end
        end
        SEL_FILL: begin
          c.advance_bytes = 5'd16;
          if (w1_r[26:25] != SZ_BAD) begin
            c.op_kind      = OP_FILL;
            c.mem_address  = (w1_r & ADDR_MASK) | RAM_LOW;
            c.mem_data     = e0_r & size_mask(w1_r[26:25]);
            c.access_size  = w1_r[26:25];
            c.repeat_count = {16'd0, e1_r[23:16]};
            c.address_step = e1_r[15:0];
          end
        end
        SEL_COPY: begin
          c.op_kind       = OP_COPY;
          c.repeat_count  = {8'd0, w1_r[15:0]};
          c.copy_source   = e0_r;
          c.mem_address   = e1_r;
          c.advance_bytes = 5'd16;
        end
        default: c.advance_bytes = 5'd8;
      endcase
    end else if (ctype != 3'd0) begin
      if (sz != SZ_BAD && fail_r) begin
        unique case (sub)
          2'd0:    c.advance_bytes = 5'd16;
          2'd1:    c.advance_bytes = 5'd24;
          2'd2:    c.skip_to_marker = 1'b1;
          default: c.advance_bytes = 5'd0;
        endcase
      end
    end else begin
      unique case (sub)
        2'd0: begin
          if (sz == SZ_BYTE) begin
            c.op_kind = OP_FILL; c.mem_address = bse; c.mem_data = {24'd0, w1_r[7:0]};
            c.access_size = SZ_BYTE; c.repeat_count = w1_r[31:8]; c.address_step = 16'sd1;
          end else if (sz == SZ_HALF) begin
            c.op_kind = OP_FILL; c.mem_address = bse; c.mem_data = {16'd0, w1_r[15:0]};
            c.access_size = SZ_HALF; c.repeat_count = {8'd0, w1_r[31:16]};
            c.address_step = 16'sd2;
          end else if (sz == SZ_WORD) begin
            c.op_kind = OP_WRITE; c.mem_address = bse; c.mem_data = w1_r;
            c.access_size = SZ_WORD;
          end
        end
        2'd1: begin
          if (ptr_ok_r && sz != SZ_BAD) begin
            c.op_kind = OP_WRITE; c.mem_address = ptr_addr_r;
            c.mem_data = w1_r & size_mask(sz); c.access_size = sz;
          end
        end
        2'd2: begin
          if (sz != SZ_BAD) begin
            c.op_kind = OP_WRITE; c.mem_address = bse;
            c.mem_data = add_sum_r & size_mask(sz); c.access_size = sz;
          end
        end
        default: begin
          if (sz == SZ_WORD) begin
            c.op_kind = OP_WRITE; c.mem_address = bse;
            c.mem_data = (hook_diff_r & BRANCH_MASK) | BRANCH_OP; c.access_size = SZ_WORD;
          end else if (sz == SZ_BAD) begin
            c.op_kind = OP_WRITE; c.mem_address = hwa;
            c.access_size = ((hwa & HW_WORD_FLAG) != 32'd0) ? SZ_WORD : SZ_HALF;
            c.mem_data = w1_r & size_mask(c.access_size);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv_en) begin
      out_valid <= v1_r;
    end
    if (adv_en) begin
      out_cmd <= c;
    end
  end

endmodule
